[rtl/c2d_pkg.sv]
package c2d_pkg;

  // Configuration port geometry and register field widths.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int RADIUS_BITS    = 2;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_BITS    = 16;

  // Register values after reset.
  localparam logic [RADIUS_BITS-1:0]    RESET_RADIUS = 2'd1;
  localparam logic [WIDTH_REG_BITS-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0]    RESET_HEIGHT = 16'd480;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_KERNEL_RADIUS = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } reg_idx_t;

  // Item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_COEF  = 1'b1;

  // Control handed from the top level to every window cell.
  typedef struct packed {
    logic en;     // pipeline advances this cycle
    logic shift;  // a pixel column enters the window
  } cell_ctrl_t;

  // Coefficient slot used by window cell (i, j) at radius rr, or -1 when
  // the cell lies outside the kernel of that radius.
  function automatic int cell_coef_idx(int mk, int i, int j, int rr);
    int s;
    int off;
    int res;
    s   = 2 * rr + 1;
    off = mk - s;
    res = -1;
    if (off >= 0 && i >= off && j >= off) res = (i - off) * s + (j - off);
    return res;
  endfunction

endpackage

[rtl/c2d_in_if.sv]
interface c2d_in_if #(
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 16,
  parameter int CIDX_BITS  = 6
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [PIXEL_BITS-1:0] pixel_value;
  logic                         frame_start;
  logic [CIDX_BITS-1:0]         coef_index;
  logic signed [COEF_BITS-1:0]  coef_value;

  modport source (output valid, cmd, pixel_value, frame_start, coef_index, coef_value,
                  input ready);
  modport sink (input valid, cmd, pixel_value, frame_start, coef_index, coef_value,
                output ready);
endinterface

[rtl/c2d_out_if.sv]
interface c2d_out_if #(
  parameter int PIXEL_BITS = 16,
  parameter int COL_BITS   = 10,
  parameter int ROW_BITS   = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] result_value;
  logic [COL_BITS-1:0]          out_col;
  logic [ROW_BITS-1:0]          out_row;
  logic                         last;

  modport source (output valid, result_value, out_col, out_row, last, input ready);
  modport sink (input valid, result_value, out_col, out_row, last, output ready);
endinterface

[rtl/c2d_ram.sv]
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write at one address return the old word.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end
endmodule

[rtl/c2d_cell.sv]
module c2d_cell #(
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  c2d_pkg::cell_ctrl_t                    ctrl,
  input  logic signed [PIXEL_BITS-1:0]           pix_in,
  input  logic signed [COEF_BITS-1:0]            coef,
  output logic signed [PIXEL_BITS-1:0]           pix_q,
  output logic signed [PIXEL_BITS+COEF_BITS-1:0] prod_q
);
  import c2d_pkg::*;

  logic signed [PIXEL_BITS-1:0]           pix_r;
  logic signed [PIXEL_BITS+COEF_BITS-1:0] prod_r;

  // Window sample: takes the neighbour's sample when a column enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (ctrl.shift) begin
      pix_r <= pix_in;
    end
  end

  // Product of the held sample and this cell's coefficient.
  always_ff @(posedge clk) begin
    if (ctrl.en) prod_r <= pix_r * coef;
  end

  assign pix_q  = pix_r;
  assign prod_q = prod_r;
endmodule

[rtl/c2d_tree.sv]
module c2d_tree #(
  parameter int N  = 49,
  parameter int W  = 38,
  parameter int MW = 27
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [MW-1:0]       meta_i,
  input  logic signed [W-1:0] val_i [N],
  output logic                vld_o,
  output logic [MW-1:0]       meta_o,
  output logic signed [W-1:0] sum_o
);
  localparam int LV  = $clog2(N);
  localparam int LVA = (LV > 0) ? LV : 1;

  logic signed [W-1:0] st_r   [LVA][N];
  logic                vld_r  [LVA];
  logic [MW-1:0]       meta_r [LVA];
  logic signed [W-1:0] src    [LVA][N];

  // Input of each level: the item for the first, the level before otherwise.
  always_comb begin
    for (int k = 0; k < LVA; k++) begin
      for (int i = 0; i < N; i++) begin
        src[k][i] = (k == 0) ? val_i[i] : st_r[(k > 0) ? k - 1 : 0][i];
      end
    end
  end

  // Pairwise sums, one level per register stage.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LVA; k++) begin
        meta_r[k] <= (k == 0) ? meta_i : meta_r[(k > 0) ? k - 1 : 0];
        for (int i = 0; i < N; i++) begin
          st_r[k][i] <= ((2 * i < N) ? src[k][(2 * i) % N] : W'(0)) +
                        ((2 * i + 1 < N) ? src[k][(2 * i + 1) % N] : W'(0));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LVA; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < LVA; k++) vld_r[k] <= (k == 0) ? vld_i : vld_r[(k > 0) ? k - 1 : 0];
    end
  end

  generate
    if (LV == 0) begin : g_flat
      assign vld_o  = vld_i;
      assign meta_o = meta_i;
      assign sum_o  = val_i[0];
    end else begin : g_tree
      assign vld_o  = vld_r[LVA-1];
      assign meta_o = meta_r[LVA-1];
      assign sum_o  = st_r[LVA-1][0];
    end
  endgenerate
endmodule

[rtl/conv2d_square_kernel_valid.sv]
// Pipeline: line store read, window shift, products, one adder-tree level per
//   register stage, then rounding into the output register.
// Throughput: one item per cycle unless a result meets a full output register,
//   set by the line stores, read and written once per pixel, and the window cell
//   row, which advances once per pixel.
// Reset: synchronous, active low; clears counters, window, coefficients and
//   registers to their defaults; line stores keep their content.
module conv2d_square_kernel_valid #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  c2d_in_if.sink                               in_ch,
  c2d_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [c2d_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [c2d_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import c2d_pkg::*;

  localparam int MAX_RADIUS = (MAX_KERNEL - 1) / 2;
  localparam int NLINES     = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int SLOT_BITS  = (NLINES > 1) ? $clog2(NLINES) : 1;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WEB        = (WIDTH_REG_BITS > COL_BITS + 1) ? WIDTH_REG_BITS : COL_BITS + 1;
  localparam int NCELL      = MAX_KERNEL * MAX_KERNEL;
  localparam int CIDX_BITS  = $clog2(NCELL + 1);
  localparam int FRAC_BITS  = COEF_BITS - 2;
  localparam int PROD_BITS  = PIXEL_BITS + COEF_BITS;
  localparam int SUM_BITS   = PROD_BITS + $clog2(NCELL + 1);
  localparam int META_BITS  = 1 + HEIGHT_BITS + COL_BITS;
  localparam logic signed [SUM_BITS:0] Q_HI =
    (SUM_BITS+1)'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_BITS:0] Q_LO = -Q_HI - 1;
  localparam logic signed [SUM_BITS:0] ROUND_HALF =
    (SUM_BITS+1)'(64'sd1 <<< (FRAC_BITS - 1));

  // Configuration registers.
  logic [RADIUS_BITS-1:0]    kr_r;
  logic [WIDTH_REG_BITS-1:0] iw_r;
  logic [HEIGHT_BITS-1:0]    ih_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kr_r <= RESET_RADIUS;
      iw_r <= RESET_WIDTH;
      ih_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KERNEL_RADIUS: kr_r <= cfg_data[RADIUS_BITS-1:0];
        REG_IMAGE_WIDTH:   iw_r <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT:  ih_r <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping.
  logic [RADIUS_BITS-1:0] r_eff;
  logic [RADIUS_BITS:0]   two_r;
  logic [WEB-1:0]         w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;

  always_comb begin
    r_eff = (kr_r > RADIUS_BITS'(MAX_RADIUS)) ? RADIUS_BITS'(MAX_RADIUS) : kr_r;
    two_r = {r_eff, 1'b0};
    if (iw_r == '0) w_eff = WEB'(1);
    else if (WEB'(iw_r) > WEB'(MAX_WIDTH)) w_eff = WEB'(MAX_WIDTH);
    else w_eff = WEB'(iw_r);
    h_eff = (ih_r == '0) ? HEIGHT_BITS'(1) : ih_r;
  end

  // Pipeline advance: stall only when a result meets a full output register.
  logic en;
  logic tree_vld;
  logic out_vld_r;

  assign en          = !(out_vld_r && !out_ch.ready && tree_vld);
  assign in_ch.ready = en;

  logic acc_pix;
  logic acc_coef;
  assign acc_pix  = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_PIXEL);
  assign acc_coef = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_COEF);

  // Raster position at the input.
  logic [COL_BITS-1:0]    col_r, col_cur, col_nxt;
  logic [HEIGHT_BITS-1:0] row_r, row_cur, row_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_cur, slot_nxt;
  logic                   res_a, last_a;

  always_comb begin
    col_cur  = in_ch.frame_start ? '0 : col_r;
    row_cur  = in_ch.frame_start ? '0 : row_r;
    slot_cur = in_ch.frame_start ? '0 : slot_r;
    res_a    = (WEB'(col_cur) < w_eff) && (row_cur < h_eff) &&
               (row_cur >= HEIGHT_BITS'(two_r)) && (WEB'(col_cur) >= WEB'(two_r));
    last_a   = (WEB'(col_cur) == w_eff - WEB'(1)) && (row_cur == h_eff - HEIGHT_BITS'(1));
    col_nxt  = col_cur + COL_BITS'(1);
    row_nxt  = row_cur;
    slot_nxt = slot_cur;
    if (WEB'(col_cur) + WEB'(1) >= w_eff) begin
      col_nxt = '0;
      if ({1'b0, row_cur} + (HEIGHT_BITS+1)'(1) >= {1'b0, h_eff}) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_cur + HEIGHT_BITS'(1);
        slot_nxt = (slot_cur == SLOT_BITS'(NLINES - 1)) ? '0 : slot_cur + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (acc_pix) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Line stores: one per buffered row, read and written at the current column.
  logic [PIXEL_BITS-1:0] ram_dout [NLINES];

  generate
    for (genvar k = 0; k < NLINES; k++) begin : g_line
      c2d_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line (
        .clk   (clk),
        .we    (acc_pix && (slot_cur == SLOT_BITS'(k))),
        .waddr (col_cur),
        .wdata (in_ch.pixel_value),
        .re    (acc_pix),
        .raddr (col_cur),
        .rdata (ram_dout[k])
      );
    end
  endgenerate

  // Stage B: item beside the line store read data.
  logic                         pix_vld_b_r, coef_vld_b_r, res_b_r;
  logic signed [PIXEL_BITS-1:0] pix_b_r;
  logic [SLOT_BITS-1:0]         slot_b_r;
  logic [CIDX_BITS-1:0]         cidx_b_r;
  logic signed [COEF_BITS-1:0]  cval_b_r;
  logic [META_BITS-1:0]         meta_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_b_r  <= 1'b0;
      coef_vld_b_r <= 1'b0;
      res_b_r      <= 1'b0;
    end else if (en) begin
      pix_vld_b_r  <= acc_pix;
      coef_vld_b_r <= acc_coef;
      res_b_r      <= acc_pix && res_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_b_r  <= in_ch.pixel_value;
      slot_b_r <= slot_cur;
      cidx_b_r <= in_ch.coef_index;
      cval_b_r <= in_ch.coef_value;
      meta_b_r <= {last_a, row_cur - HEIGHT_BITS'(r_eff), col_cur - COL_BITS'(r_eff)};
    end
  end

  // New window column: the pixel at the bottom, older rows above it.
  logic signed [PIXEL_BITS-1:0] col_feed [MAX_KERNEL];

  always_comb begin
    int sel;
    col_feed[MAX_KERNEL-1] = pix_b_r;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      sel = int'(slot_b_r) - d;
      if (sel < 0) sel = sel + NLINES;
      col_feed[MAX_KERNEL-1-d] = ram_dout[SLOT_BITS'(sel)];
    end
  end

  // Coefficient registers, written as a load item passes stage B.
  logic signed [COEF_BITS-1:0] coef_r [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NCELL; k++) coef_r[k] <= '0;
    end else if (en && coef_vld_b_r) begin
      for (int k = 0; k < NCELL; k++) begin
        if (cidx_b_r == CIDX_BITS'(k)) coef_r[k] <= cval_b_r;
      end
    end
  end

  // Stages C and D: result flag and position follow the window and products.
  logic                 res_c_r, res_d_r;
  logic [META_BITS-1:0] meta_c_r, meta_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_c_r <= 1'b0;
      res_d_r <= 1'b0;
    end else if (en) begin
      res_c_r <= res_b_r;
      res_d_r <= res_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_c_r <= meta_b_r;
      meta_d_r <= meta_c_r;
    end
  end

  // Window: a row of cells per kernel row, shifting left one column per pixel.
  cell_ctrl_t                   cctrl;
  logic signed [PIXEL_BITS-1:0] cpix  [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_BITS-1:0]  cprod [MAX_KERNEL][MAX_KERNEL];
  logic signed [SUM_BITS-1:0]   prod_ext [NCELL];

  assign cctrl = '{en: en, shift: en && pix_vld_b_r};

  generate
    for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_row
      for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_col
        logic signed [COEF_BITS-1:0] cf;

        // Coefficient slot of this cell at the current radius.
        always_comb begin
          int idx;
          cf = '0;
          for (int rr = 0; rr <= MAX_RADIUS; rr++) begin
            idx = cell_coef_idx(MAX_KERNEL, i, j, rr);
            if (int'(r_eff) == rr && idx >= 0) cf = coef_r[(idx >= 0) ? idx : 0];
          end
        end

        c2d_cell #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .ctrl   (cctrl),
          .pix_in ((j == MAX_KERNEL - 1) ? col_feed[i] : cpix[i][(j + 1) % MAX_KERNEL]),
          .coef   (cf),
          .pix_q  (cpix[i][j]),
          .prod_q (cprod[i][j])
        );

        assign prod_ext[i*MAX_KERNEL+j] = SUM_BITS'(cprod[i][j]);
      end
    end
  endgenerate

  // Registered adder tree over the products.
  logic [META_BITS-1:0]       tree_meta;
  logic signed [SUM_BITS-1:0] tree_sum;

  c2d_tree #(.N(NCELL), .W(SUM_BITS), .MW(META_BITS)) u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (res_d_r),
    .meta_i (meta_d_r),
    .val_i  (prod_ext),
    .vld_o  (tree_vld),
    .meta_o (tree_meta),
    .sum_o  (tree_sum)
  );

  // Round half up, drop the fraction bits and saturate.
  logic signed [SUM_BITS:0]     rsum, qfull;
  logic signed [PIXEL_BITS-1:0] qsat;

  always_comb begin
    rsum  = SUM_BITS'(tree_sum) + ROUND_HALF;
    qfull = rsum >>> FRAC_BITS;
    if (qfull > Q_HI) qsat = PIXEL_BITS'(Q_HI);
    else if (qfull < Q_LO) qsat = PIXEL_BITS'(Q_LO);
    else qsat = PIXEL_BITS'(qfull);
  end

  // Output register.
  logic signed [PIXEL_BITS-1:0] res_val_r;
  logic [META_BITS-1:0]         res_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en && tree_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tree_vld) begin
      res_val_r  <= qsat;
      res_meta_r <= tree_meta;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = res_val_r;
  assign out_ch.out_col      = res_meta_r[COL_BITS-1:0];
  assign out_ch.out_row      = res_meta_r[COL_BITS +: HEIGHT_BITS];
  assign out_ch.last         = res_meta_r[META_BITS-1];

  // The input stalls only while a result waits in the output register.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_vld_r)
    else $error("input stalled without a waiting result");

  // After a pixel the column stays inside the row when the width is unchanged.
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    acc_pix ##1 $stable(iw_r) |-> (WEB'(col_r) < w_eff))
    else $error("column counter ran past the row width");

endmodule

[tb/conv2d_square_kernel_valid_tb.sv]
`timescale 1ns / 100ps

module conv2d_square_kernel_valid_tb;
  import c2d_pkg::*;

  localparam int MK       = 7;
  localparam int MW       = 1024;
  localparam int NL       = MK - 1;
  localparam int SETTLE   = 16;
  localparam int QUIET_MAX = 4000;

  typedef struct {
    logic               cmd;
    logic signed [15:0] pix;
    logic               fs;
    logic [5:0]         cidx;
    logic signed [15:0] cval;
  } stim_item_t;

  typedef struct {
    logic signed [15:0] value;
    logic [9:0]         col;
    logic [15:0]        row;
    logic               last;
  } filt_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  c2d_in_if  in_ch ();
  c2d_out_if out_ch ();

  conv2d_square_kernel_valid i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Queues of items waiting to be sent and of filter results still due.
  stim_item_t   pixel_queue[$];
  filt_result_t due_results[$];
  stim_item_t   cur_item;

  // Shadow copy of the filter state.
  longint        rows_mem[NL*MW];
  longint        win[MK][MK];
  longint        taps[MK*MK];
  int unsigned   pos_col;
  int unsigned   pos_row;
  int unsigned   reg_radius;
  int unsigned   reg_width;
  int unsigned   reg_height;

  int  errors;
  int  n_in;
  int  n_out;
  int  n_pixels;
  int  n_tiles;
  bit  hold_send;
  bit  gaps_on;
  bit  stalls_on;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow state by one pixel and queue the result it completes.
  task automatic run_pixel(input logic signed [15:0] pv, input logic fs);
    int unsigned  rr;
    int unsigned  ww;
    int unsigned  hh;
    int unsigned  c;
    int unsigned  rw;
    int unsigned  sd;
    int unsigned  sl;
    bit           in_tile;
    longint       acc;
    longint       q;
    filt_result_t res;
    rr = reg_radius;
    sd = 2 * rr + 1;
    ww = (reg_width == 0) ? 1 : ((reg_width > MW) ? MW : reg_width);
    hh = (reg_height == 0) ? 1 : reg_height;
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    c = pos_col;
    rw = pos_row;
    in_tile = (c < ww) && (rw < hh);
    for (int ky = 0; ky < MK; ky++)
      for (int kx = 0; kx < MK - 1; kx++)
        win[ky][kx] = win[ky][kx+1];
    for (int d = 1; d < MK; d++) begin
      sl = ((rw % NL) + NL - (d % NL)) % NL;
      win[MK-1-d][MK-1] = rows_mem[sl*MW + (c % MW)];
    end
    win[MK-1][MK-1] = pv;
    rows_mem[(rw % NL)*MW + (c % MW)] = pv;
    if (c + 1 >= ww) begin
      pos_col = 0;
      pos_row = (rw + 1 >= hh) ? 0 : rw + 1;
    end else begin
      pos_col = c + 1;
    end
    if (in_tile && rw >= 2 * rr && c >= 2 * rr) begin
      acc = 0;
      for (int ky = 0; ky < sd; ky++)
        for (int kx = 0; kx < sd; kx++)
          acc += win[MK-sd+ky][MK-sd+kx] * taps[ky*sd+kx];
      // Round half up, then floor shift by the fraction width.
      q = (acc + 64'sd8192) >>> 14;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.value = q[15:0];
      res.col = 10'(c - rr);
      res.row = 16'(rw - rr);
      res.last = (c == ww - 1) && (rw == hh - 1);
      due_results.push_back(res);
    end
  endtask

  // Source side: present queued items, update the shadow state on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n_in++;
        if (cur_item.cmd == CMD_COEF) begin
          if (cur_item.cidx < MK * MK) taps[cur_item.cidx] = cur_item.cval;
        end else begin
          run_pixel(cur_item.pix, cur_item.fs);
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pixel_queue.size() > 0 && !hold_send &&
            !(gaps_on && $urandom_range(0, 99) < 18)) begin
          cur_item = pixel_queue.pop_front();
          in_ch.cmd         <= cur_item.cmd;
          in_ch.pixel_value <= cur_item.pix;
          in_ch.frame_start <= cur_item.fs;
          in_ch.coef_index  <= cur_item.cidx;
          in_ch.coef_value  <= cur_item.cval;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: compare each accepted result with the oldest one due.
  always @(posedge clk) begin
    filt_result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (due_results.size() == 0) begin
          $error("unexpected result value=%0d col=%0d row=%0d", out_ch.result_value,
                 out_ch.out_col, out_ch.out_row);
          errors++;
        end else begin
          exp_res = due_results.pop_front();
          if (out_ch.result_value !== exp_res.value) begin
            $error("result_value: expected %0d, got %0d", exp_res.value,
                   out_ch.result_value);
            errors++;
          end
          if (out_ch.out_col !== exp_res.col) begin
            $error("out_col: expected %0d, got %0d", exp_res.col, out_ch.out_col);
            errors++;
          end
          if (out_ch.out_row !== exp_res.row) begin
            $error("out_row: expected %0d, got %0d", exp_res.row, out_ch.out_row);
            errors++;
          end
          if (out_ch.last !== exp_res.last) begin
            $error("last: expected %0d, got %0d", exp_res.last, out_ch.last);
            errors++;
          end
        end
      end
      out_ch.ready <= !(stalls_on && $urandom_range(0, 99) < 18);
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    int prev_total;
    int quiet;
    if (n_in + n_out != prev_total) begin
      prev_total = n_in + n_out;
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("conv2d_square_kernel_valid: mismatch");
        $finish;
      end
    end
  end

  task automatic push_pixel(input logic signed [15:0] pv, input logic fs);
    stim_item_t it;
    it.cmd = CMD_PIXEL;
    it.pix = pv;
    it.fs = fs;
    it.cidx = 6'($urandom);
    it.cval = 16'($urandom);
    pixel_queue.push_back(it);
    n_pixels++;
  endtask

  task automatic push_coef(input logic [5:0] idx, input logic signed [15:0] val);
    stim_item_t it;
    it.cmd = CMD_COEF;
    it.pix = 16'($urandom);
    it.fs = 1'($urandom);
    it.cidx = idx;
    it.cval = val;
    pixel_queue.push_back(it);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: pick_value = 16'sh7fff;
      1: pick_value = 16'sh8000;
      2: pick_value = 16'sh0000;
      default: pick_value = 16'($urandom);
    endcase
  endfunction

  // Wait until everything sent has been answered and the pipeline has drained.
  task automatic drain();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers while the filter is idle.
  task automatic set_geometry(input int unsigned r, input int unsigned w,
                              input int unsigned h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_KERNEL_RADIUS;
    cfg_data <= 16'(r);
    @(posedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= 16'(w);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= 16'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_radius = r & 3;
    reg_width = w & 16'h7ff;
    reg_height = h & 16'hffff;
  endtask

  task automatic load_kernel(input int unsigned r);
    int unsigned sd;
    sd = 2 * r + 1;
    for (int k = 0; k < sd * sd; k++) push_coef(6'(k), pick_value() >>> $urandom_range(0, 4));
    push_coef(6'($urandom_range(49, 63)), pick_value());
  endtask

  // Whole tiles of random pixels, with occasional coefficient changes inside.
  task automatic send_tiles(input int unsigned w, input int unsigned h, input int tiles);
    for (int t = 0; t < tiles; t++) begin
      n_tiles++;
      for (int p = 0; p < w * h; p++) begin
        push_pixel(pick_value(), p == 0);
        if ($urandom_range(0, 99) < 3) push_coef(6'($urandom_range(0, 63)), pick_value());
      end
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int          phase;
    n_in = 0;
    n_out = 0;
    n_pixels = 0;
    n_tiles = 0;
    errors = 0;
    hold_send = 1'b0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KERNEL_RADIUS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_PIXEL;
    in_ch.pixel_value = '0;
    in_ch.frame_start = 1'b0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    out_ch.ready = 1'b0;
    foreach (rows_mem[i]) rows_mem[i] = 0;
    foreach (win[i, j]) win[i][j] = 0;
    foreach (taps[i]) taps[i] = 0;
    pos_col = 0;
    pos_row = 0;
    reg_radius = RESET_RADIUS;
    reg_width = RESET_WIDTH;
    reg_height = RESET_HEIGHT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturation both ways, ignored coefficient slots, a 3x3 tile.
    set_geometry(1, 3, 3);
    for (int k = 0; k < 9; k++) push_coef(6'(k), 16'sh8000);
    push_coef(6'd49, 16'sh7fff);
    push_coef(6'd63, 16'sh7fff);
    for (int p = 0; p < 9; p++) push_pixel(16'sh7fff, p == 0);
    for (int p = 0; p < 9; p++) push_pixel(16'sh8000, p == 0);

    // Directed: largest radius on a 7x7 tile, clamped widths and heights.
    set_geometry(3, 7, 7);
    load_kernel(3);
    send_tiles(7, 7, 1);
    set_geometry(1, 0, 0);
    send_tiles(1, 1, 4);
    set_geometry(0, 1, 65535);
    load_kernel(0);
    for (int p = 0; p < 60; p++) push_pixel(pick_value(), p == 0);
    set_geometry(3, 20, 6);
    send_tiles(20, 6, 1);
    set_geometry(0, 2047, 1);
    send_tiles(1024, 1, 1);

    // Sizes changed in the middle of a tile: column and row past the new size.
    set_geometry(1, 12, 10);
    load_kernel(1);
    for (int p = 0; p < 40; p++) push_pixel(pick_value(), p == 0);
    set_geometry(1, 3, 8);
    for (int p = 0; p < 10; p++) push_pixel(pick_value(), 1'b0);
    set_geometry(1, 3, 5);
    for (int p = 0; p < 12; p++) push_pixel(pick_value(), 1'b0);
    // A restart in the middle of a tile.
    for (int p = 0; p < 7; p++) push_pixel(pick_value(), p == 0);
    send_tiles(3, 5, 1);

    // Random phases of small tiles.
    phase = 0;
    while (phase < 3) begin
      r = $urandom_range(0, 3);
      w = $urandom_range(1, 2 * r + 10);
      h = $urandom_range(1, 2 * r + 8);
      gaps_on = (phase != 1);
      stalls_on = (phase != 1);
      set_geometry(r, w, h);
      load_kernel(r);
      send_tiles(w, h, $urandom_range(1, 3));
      // Hold the sender back once until every result so far has come out.
      if (phase == 2) begin
        hold_send = 1'b1;
        while (due_results.size() != 0) @(posedge clk);
        hold_send = 1'b0;
      end
      phase++;
    end

    drain();
    $display("Sent %0d items (%0d pixels) over %0d tiles; checked %0d results.",
             n_in, n_pixels, n_tiles, n_out);
    $display("Radii 0 to 3, widths 1 to 1024, clamped and mid-tile size changes.");
    if (errors == 0) begin
      $display("conv2d_square_kernel_valid: match");
    end else begin
      $display("conv2d_square_kernel_valid: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/c2d_pkg.sv
rtl/c2d_in_if.sv
rtl/c2d_out_if.sv
rtl/c2d_ram.sv
rtl/c2d_cell.sv
rtl/c2d_tree.sv
rtl/conv2d_square_kernel_valid.sv
tb/conv2d_square_kernel_valid_tb.sv
